// ----- rtl/blink_pattern_relay_duty_limiter_macros.svh -----
// Assertion macros shared by the blink pattern relay duty limiter modules.
`ifndef BLINK_PATTERN_RELAY_DUTY_LIMITER_MACROS_SVH
`define BLINK_PATTERN_RELAY_DUTY_LIMITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPRDL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define BPRDL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/bprdl_pkg.sv -----
// Shared types and constants for the blink pattern relay duty limiter.
`timescale 1ns / 1ps
package bprdl_pkg;

  localparam int PAT_W    = 32;
  localparam int LEVEL_W  = 13;
  localparam int BRT_W    = 9;
  localparam int DUTY_W   = 7;
  localparam int TICKS_W  = 16;
  localparam int HEAT_W   = 24;
  localparam int CD_W     = 17;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 24;

  // Operation codes on the input word.
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET_RGB  = 2'd1;
  localparam logic [1:0] OP_SET_BLUE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_DUTY       = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_OPEN_TICKS = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_HEAT_LIMIT = 2'd3;

  // Command queue depth between front and back.
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  typedef enum logic [1:0] {
    K_TICK,
    K_SET_RGB,
    K_SET_BLUE,
    K_NOP
  } kind_t;

  // One classified word. pat_a carries red, or blue for a blue update.
  typedef struct packed {
    kind_t            kind;
    logic [PAT_W-1:0] pat_a;
    logic [PAT_W-1:0] pat_b;
    logic [PAT_W-1:0] pat_c;
    logic             open_req;
  } qent_t;

endpackage

// ----- rtl/bprdl_front.sv -----
// Front end: classifies incoming words into queue entries.
`timescale 1ns / 1ps
module bprdl_front import bprdl_pkg::*; (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  input  logic [PAT_W-1:0] in_red_pattern,
  input  logic [PAT_W-1:0] in_green_pattern,
  input  logic [PAT_W-1:0] in_buzzer_pattern,
  input  logic [PAT_W-1:0] in_blue_pattern,
  input  logic             in_open_request,
  input  logic             q_full,
  output logic             q_push,
  output qent_t            q_ent
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_ent.pat_a    = in_red_pattern;
    q_ent.pat_b    = in_green_pattern;
    q_ent.pat_c    = in_buzzer_pattern;
    q_ent.open_req = 1'b0;
    case (in_operation)
      OP_TICK: begin
        q_ent.kind = K_TICK;
      end
      OP_SET_RGB: begin
        q_ent.kind     = K_SET_RGB;
        q_ent.open_req = in_open_request;
      end
      OP_SET_BLUE: begin
        q_ent.kind  = K_SET_BLUE;
        q_ent.pat_a = in_blue_pattern;
      end
      default: begin
        q_ent.kind = K_NOP;
      end
    endcase
  end

endmodule

// ----- rtl/bprdl_queue.sv -----
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps
module bprdl_queue import bprdl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output qent_t head_ent
);
`include "blink_pattern_relay_duty_limiter_macros.svh"

  qent_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head_ent  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  `BPRDL_ASSERT_IMP(a_count_bound, 1'b1, count_r <= (QAW+1)'(QDEPTH))
  `BPRDL_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1)
  `BPRDL_ASSERT_NXT(a_count_down, pop && !push, count_r == $past(count_r) - 1'b1)

endmodule

// ----- rtl/bprdl_back.sv -----
// Back end: executes queued words against the pattern, relay and heat state.
`timescale 1ns / 1ps
module bprdl_back import bprdl_pkg::*; #(
  parameter int LED_MAX = 8191
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic                q_not_empty,
  input  qent_t               q_ent,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LEVEL_W-1:0]  out_red_level,
  output logic [LEVEL_W-1:0]  out_green_level,
  output logic [LEVEL_W-1:0]  out_blue_level,
  output logic                out_buzzer_on,
  output logic                out_relay_on,
  output logic                out_open_refused
);
`include "blink_pattern_relay_duty_limiter_macros.svh"

  localparam logic [15:0] CMAX_RED   = 16'(LED_MAX);
  localparam logic [15:0] CMAX_GREEN = CMAX_RED / 4;
  localparam logic [15:0] CMAX_BLUE  = CMAX_RED / 2;
  localparam logic [HEAT_W-1:0] HEAT_TOP = '1;
  localparam int PROD_W = BRT_W + 16;

  function automatic logic [PAT_W-1:0] advance(input logic [PAT_W-1:0] p);
    logic [PAT_W-1:0] r;
    r = p >> 1;
    if (p[PAT_W-1]) begin
      r[PAT_W-1] = 1'b1;
      r[PAT_W-2] = p[0];
    end
    return r;
  endfunction

  logic [BRT_W-1:0]   brightness_r;
  logic [DUTY_W-1:0]  duty_r;
  logic [TICKS_W-1:0] open_ticks_r;
  logic [HEAT_W-1:0]  heat_limit_r;

  logic [PAT_W-1:0]   red_r, green_r, blue_r, buzz_r;
  logic [PAT_W-1:0]   red_nxt, green_nxt, blue_nxt, buzz_nxt;
  logic [CD_W-1:0]    countdown_r, countdown_nxt, cd_dec;
  logic [HEAT_W-1:0]  heat_r, heat_nxt;
  logic [LEVEL_W-1:0] hred_r, hgreen_r, hblue_r;
  logic [LEVEL_W-1:0] hred_nxt, hgreen_nxt, hblue_nxt;
  logic               hbuzz_r, hbuzz_nxt;
  logic               refused;

  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic               out_buzz_r, out_relay_on_r, out_refused_r;

  logic [BRT_W-1:0]   brt_c;
  logic [DUTY_W-1:0]  duty_c;
  logic [DUTY_W-1:0]  rise;
  logic [HEAT_W:0]    heat_sum;
  logic [PROD_W-1:0]  prod_red, prod_green, prod_blue;

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  // Clamp out-of-range settings, then scale each color maximum.
  assign brt_c      = (brightness_r > 9'd256) ? 9'd256 : brightness_r;
  assign duty_c     = (duty_r > 7'd100) ? 7'd100 : duty_r;
  assign rise       = 7'd100 - duty_c;
  assign heat_sum   = {1'b0, heat_r} + (HEAT_W+1)'(rise);
  assign prod_red   = PROD_W'(brt_c) * PROD_W'(CMAX_RED);
  assign prod_green = PROD_W'(brt_c) * PROD_W'(CMAX_GREEN);
  assign prod_blue  = PROD_W'(brt_c) * PROD_W'(CMAX_BLUE);
  assign cd_dec     = (countdown_r != '0) ? countdown_r - 1'b1 : countdown_r;

  always_comb begin
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    buzz_nxt      = buzz_r;
    countdown_nxt = countdown_r;
    heat_nxt      = heat_r;
    hred_nxt      = hred_r;
    hgreen_nxt    = hgreen_r;
    hblue_nxt     = hblue_r;
    hbuzz_nxt     = hbuzz_r;
    refused       = 1'b0;
    if (q_pop) begin
      case (q_ent.kind)
        K_TICK: begin
          hred_nxt   = red_r[0] ? prod_red[LEVEL_W+7:8] : '0;
          hgreen_nxt = green_r[0] ? prod_green[LEVEL_W+7:8] : '0;
          hblue_nxt  = blue_r[0] ? prod_blue[LEVEL_W+7:8] : '0;
          hbuzz_nxt  = buzz_r[0];
          red_nxt    = advance(red_r);
          green_nxt  = advance(green_r);
          blue_nxt   = advance(blue_r);
          buzz_nxt   = advance(buzz_r);
          countdown_nxt = cd_dec;
          if (cd_dec != '0) begin
            heat_nxt = heat_sum[HEAT_W] ? HEAT_TOP : heat_sum[HEAT_W-1:0];
          end else if (heat_r > HEAT_W'(duty_c)) begin
            heat_nxt = heat_r - HEAT_W'(duty_c);
          end else begin
            heat_nxt = '0;
          end
        end
        K_SET_RGB: begin
          red_nxt   = q_ent.pat_a;
          green_nxt = q_ent.pat_b;
          buzz_nxt  = q_ent.pat_c;
          if (q_ent.open_req) begin
            if (heat_r <= heat_limit_r) begin
              countdown_nxt = CD_W'(open_ticks_r) + 1'b1;
            end else begin
              refused = 1'b1;
            end
          end
        end
        K_SET_BLUE: begin
          blue_nxt = q_ent.pat_a;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 9'd128;
      duty_r       <= 7'd50;
      open_ticks_r <= 16'd50;
      heat_limit_r <= 24'd250000;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BRIGHTNESS: brightness_r <= cfg_wdata[BRT_W-1:0];
        CFG_DUTY:       duty_r       <= cfg_wdata[DUTY_W-1:0];
        CFG_OPEN_TICKS: open_ticks_r <= cfg_wdata[TICKS_W-1:0];
        CFG_HEAT_LIMIT: heat_limit_r <= cfg_wdata[HEAT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      buzz_r      <= 32'h7;
      countdown_r <= '0;
      heat_r      <= '0;
      hred_r      <= '0;
      hgreen_r    <= '0;
      hblue_r     <= '0;
      hbuzz_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
      buzz_r      <= buzz_nxt;
      countdown_r <= countdown_nxt;
      heat_r      <= heat_nxt;
      hred_r      <= hred_nxt;
      hgreen_r    <= hgreen_nxt;
      hblue_r     <= hblue_nxt;
      hbuzz_r     <= hbuzz_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_red_r      <= hred_nxt;
      out_green_r    <= hgreen_nxt;
      out_blue_r     <= hblue_nxt;
      out_buzz_r     <= hbuzz_nxt;
      out_relay_on_r <= (countdown_nxt != '0);
      out_refused_r  <= refused;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_level    = out_red_r;
  assign out_green_level  = out_green_r;
  assign out_blue_level   = out_blue_r;
  assign out_buzzer_on    = out_buzz_r;
  assign out_relay_on     = out_relay_on_r;
  assign out_open_refused = out_refused_r;

  `BPRDL_ASSERT_NXT(a_relay_match, q_pop, out_relay_on_r == (countdown_r != '0))
  `BPRDL_ASSERT_NXT(a_refuse_only_rgb, q_pop && (q_ent.kind != K_SET_RGB), !out_refused_r)
  `BPRDL_ASSERT_NXT(a_heat_decays, q_pop && (q_ent.kind == K_TICK) && (countdown_r <= 17'd1),
                    heat_r <= $past(heat_r))

endmodule

// ----- rtl/blink_pattern_relay_duty_limiter.sv -----
// Top level of the blink pattern relay duty limiter.
// An accepted word is written into the queue, then popped and registered into the output register behind out_valid.
// Throughput: one word per cycle; the back end retires one queued word each cycle
//   that its output register is empty or being drained.
// The input side keeps taking words while a result waits, until the two-entry queue fills.
// Reset (rst_n low, synchronous) empties the queue and output, restores register
//   defaults, clears patterns, countdown, heat and held levels, and loads buzzer 0x7.
`timescale 1ns / 1ps
module blink_pattern_relay_duty_limiter import bprdl_pkg::*; #(
  parameter int LED_MAX = 8191
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  // Input word channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [PAT_W-1:0]    in_red_pattern,
  input  logic [PAT_W-1:0]    in_green_pattern,
  input  logic [PAT_W-1:0]    in_buzzer_pattern,
  input  logic [PAT_W-1:0]    in_blue_pattern,
  input  logic                in_open_request,
  // Result word channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LEVEL_W-1:0]  out_red_level,
  output logic [LEVEL_W-1:0]  out_green_level,
  output logic [LEVEL_W-1:0]  out_blue_level,
  output logic                out_buzzer_on,
  output logic                out_relay_on,
  output logic                out_open_refused
);

  // Front to queue
  logic  q_full;
  logic  q_push;
  qent_t q_in_ent;
  // Queue to back
  logic  q_not_empty;
  logic  q_pop;
  qent_t q_head_ent;

  // Decode the operation into a command kind; accept whenever the queue has room.
  bprdl_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_red_pattern    (in_red_pattern),
    .in_green_pattern  (in_green_pattern),
    .in_buzzer_pattern (in_buzzer_pattern),
    .in_blue_pattern   (in_blue_pattern),
    .in_open_request   (in_open_request),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_ent             (q_in_ent)
  );

  // Hold classified words so the front and back stall independently.
  bprdl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ent  (q_in_ent),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_ent  (q_head_ent)
  );

  // Execute: advance patterns on ticks, grant or refuse relay opens against
  // the heat limit, track heat, and register the result word.
  bprdl_back #(
    .LED_MAX (LED_MAX)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .q_not_empty      (q_not_empty),
    .q_ent            (q_head_ent),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red_level    (out_red_level),
    .out_green_level  (out_green_level),
    .out_blue_level   (out_blue_level),
    .out_buzzer_on    (out_buzzer_on),
    .out_relay_on     (out_relay_on),
    .out_open_refused (out_open_refused)
  );

endmodule

// ----- verif/blink_pattern_relay_duty_limiter_tb.sv -----
// Self-checking testbench for the blink pattern relay duty limiter.
`timescale 1ns / 1ps
module blink_pattern_relay_duty_limiter_tb;
  import bprdl_pkg::*;

  localparam int LED_MAX = 8191;
  localparam int HEAT_TOP = 24'hFF_FFFF;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Pattern slots in the board image
  localparam int SLOT_RED = 0;
  localparam int SLOT_GREEN = 1;
  localparam int SLOT_BLUE = 2;
  localparam int SLOT_BUZZ = 3;

  // One result word as the board should report it
  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic buzzer;
    logic relay;
    logic refused;
  } relay_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_operation;
  logic [PAT_W-1:0] in_red_pattern;
  logic [PAT_W-1:0] in_green_pattern;
  logic [PAT_W-1:0] in_buzzer_pattern;
  logic [PAT_W-1:0] in_blue_pattern;
  logic in_open_request;
  logic out_valid;
  logic out_ready;
  logic [LEVEL_W-1:0] out_red_level;
  logic [LEVEL_W-1:0] out_green_level;
  logic [LEVEL_W-1:0] out_blue_level;
  logic out_buzzer_on;
  logic out_relay_on;
  logic out_open_refused;

  blink_pattern_relay_duty_limiter #(.LED_MAX(LED_MAX)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_red_pattern(in_red_pattern),
    .in_green_pattern(in_green_pattern),
    .in_buzzer_pattern(in_buzzer_pattern),
    .in_blue_pattern(in_blue_pattern),
    .in_open_request(in_open_request),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red_level(out_red_level),
    .out_green_level(out_green_level),
    .out_blue_level(out_blue_level),
    .out_buzzer_on(out_buzzer_on),
    .out_relay_on(out_relay_on),
    .out_open_refused(out_open_refused)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copies of the configuration registers
  int shadow_brightness;
  int shadow_duty;
  int shadow_open_ticks;
  int shadow_heat_limit;

  // Board image: patterns, relay countdown, heat and the held drive levels
  logic [PAT_W-1:0] board_pat [4];
  int board_countdown;
  int board_heat;
  logic [LEVEL_W-1:0] board_level [3];
  logic board_buzzer;

  // Results the board owes us, oldest first
  relay_result_t pending_results[$];

  // Knobs shared between the stimulus and the result sink
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_off_cycles = 0;

  // Run statistics
  int errors = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int grants = 0;
  int refusals = 0;
  int peak_heat = 0;

  // Drive level of one LED at full pattern bit, per current brightness
  function automatic logic [LEVEL_W-1:0] led_level(input int slot);
    int brt;
    int cmax;
    int lvl;
    brt = (shadow_brightness > 256) ? 256 : shadow_brightness;
    if (slot == SLOT_GREEN) cmax = LED_MAX / 4;
    else if (slot == SLOT_BLUE) cmax = LED_MAX / 2;
    else cmax = LED_MAX;
    lvl = ((brt * cmax) >> 8) & 32'h1FFF;
    return lvl[LEVEL_W-1:0];
  endfunction

  // Looping patterns rotate bit 0 into bit 30; plain ones shift right
  function automatic logic [PAT_W-1:0] shift_pattern(input logic [PAT_W-1:0] p);
    if (p[31]) return {1'b1, p[0], p[30:1]};
    return p >> 1;
  endfunction

  function automatic void reset_board_image();
    shadow_brightness = 128;
    shadow_duty = 50;
    shadow_open_ticks = 50;
    shadow_heat_limit = 250000;
    board_pat[SLOT_RED] = '0;
    board_pat[SLOT_GREEN] = '0;
    board_pat[SLOT_BLUE] = '0;
    board_pat[SLOT_BUZZ] = 32'h7;
    board_countdown = 0;
    board_heat = 0;
    for (int s = 0; s < 3; s++) board_level[s] = '0;
    board_buzzer = 1'b0;
  endfunction

  // Advance the board image by one accepted word and queue its result
  task automatic predict_word(input logic [1:0] op, input logic [PAT_W-1:0] red,
                              input logic [PAT_W-1:0] green,
                              input logic [PAT_W-1:0] buzzer,
                              input logic [PAT_W-1:0] blue, input logic open_req);
    relay_result_t r;
    int duty;
    int rise;
    r.refused = 1'b0;
    case (op)
      OP_TICK: begin
        duty = (shadow_duty > 100) ? 100 : shadow_duty;
        for (int s = 0; s < 3; s++)
          board_level[s] = board_pat[s][0] ? led_level(s) : '0;
        board_buzzer = board_pat[SLOT_BUZZ][0];
        for (int s = 0; s < 4; s++) board_pat[s] = shift_pattern(board_pat[s]);
        if (board_countdown != 0) board_countdown--;
        // Heat rises while the relay stays open, decays otherwise
        if (board_countdown != 0) begin
          rise = 100 - duty;
          board_heat = (board_heat > HEAT_TOP - rise) ? HEAT_TOP : board_heat + rise;
        end else if (board_heat > duty) begin
          board_heat -= duty;
        end else begin
          board_heat = 0;
        end
        if (board_heat > peak_heat) peak_heat = board_heat;
      end
      OP_SET_RGB: begin
        board_pat[SLOT_RED] = red;
        board_pat[SLOT_GREEN] = green;
        board_pat[SLOT_BUZZ] = buzzer;
        if (open_req) begin
          if (board_heat <= shadow_heat_limit) begin
            board_countdown = shadow_open_ticks + 1;
            grants++;
          end else begin
            r.refused = 1'b1;
            refusals++;
          end
        end
      end
      OP_SET_BLUE: begin
        board_pat[SLOT_BLUE] = blue;
      end
      default: begin
      end
    endcase
    r.red = board_level[SLOT_RED];
    r.green = board_level[SLOT_GREEN];
    r.blue = board_level[SLOT_BLUE];
    r.buzzer = board_buzzer;
    r.relay = (board_countdown != 0);
    pending_results.push_back(r);
  endtask

  // Offer one word, hold it until taken, then sometimes drop valid and idle
  task automatic send_word(input logic [1:0] op, input logic [PAT_W-1:0] red,
                           input logic [PAT_W-1:0] green,
                           input logic [PAT_W-1:0] buzzer,
                           input logic [PAT_W-1:0] blue, input logic open_req);
    in_valid <= 1'b1;
    in_operation <= op;
    in_red_pattern <= red;
    in_green_pattern <= green;
    in_buzzer_pattern <= buzzer;
    in_blue_pattern <= blue;
    in_open_request <= open_req;
    do @(posedge clk); while (!in_ready);
    predict_word(op, red, green, buzzer, blue, open_req);
    if (tx_idle_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Shorthand for a tick with junk payload, which the block must ignore
  task automatic send_tick();
    send_word(OP_TICK, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
  endtask

  // Stop offering and wait for every owed result, plus a little slack
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register writes only go in with the board idle
  task automatic set_reg(input logic [CFG_AW-1:0] idx, input int value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_BRIGHTNESS: shadow_brightness = value & 32'h1FF;
      CFG_DUTY:       shadow_duty = value & 32'h7F;
      CFG_OPEN_TICKS: shadow_open_ticks = value & 32'hFFFF;
      CFG_HEAT_LIMIT: shadow_heat_limit = value & 32'hFF_FFFF;
      default: begin
      end
    endcase
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare each taken result word with the oldest owed one
  always @(posedge clk) begin : result_check
    relay_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result word with nothing expected, expected none, actual relay %0b",
                 $time, out_relay_on);
      end else begin
        want = pending_results.pop_front();
        check_field("red_level", want.red, out_red_level);
        check_field("green_level", want.green, out_green_level);
        check_field("blue_level", want.blue, out_blue_level);
        check_field("buzzer_on", want.buzzer, out_buzzer_on);
        check_field("relay_on", want.relay, out_relay_on);
        check_field("open_refused", want.refused, out_open_refused);
        results_checked++;
      end
    end
  end

  // Result sink: random stalls, or a counted hold-off when asked for
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (rx_idle_on) begin
        out_ready <= ($urandom_range(99) >= 33);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Power-on state: unused op reports zeros, buzzer starts from 0x7
  task automatic test_power_on();
    send_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, 1'b1);
    send_tick();
    send_tick();
  endtask

  // Looping versus plain shifting, blue handled on its own word
  task automatic test_pattern_shift();
    set_reg(CFG_BRIGHTNESS, 256);
    send_word(OP_SET_BLUE, $urandom, $urandom, $urandom, 32'h8000_0003, 1'b1);
    send_word(OP_SET_RGB, 32'h8000_0001, 32'hAAAA_AAAA, 32'h8000_0000, $urandom, 1'b0);
    send_tick();
    send_tick();
    send_tick();
  endtask

  // Brightness from dark through full scale and beyond it
  task automatic test_brightness_extremes();
    send_word(OP_SET_RGB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'h0, 1'b0);
    send_word(OP_SET_BLUE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    set_reg(CFG_BRIGHTNESS, 0);
    send_tick();
    set_reg(CFG_BRIGHTNESS, 257);
    send_tick();
    set_reg(CFG_BRIGHTNESS, 511);
    send_tick();
    set_reg(CFG_BRIGHTNESS, 256);
    send_tick();
  endtask

  // Relay grants, restart, zero-length open, heat floor and limit edges
  task automatic test_relay_heat();
    set_reg(CFG_DUTY, 127);
    send_tick();
    set_reg(CFG_OPEN_TICKS, 0);
    send_word(OP_SET_RGB, 32'h1, 32'h2, 32'h0, 32'h0, 1'b1);
    send_tick();
    set_reg(CFG_OPEN_TICKS, 4);
    set_reg(CFG_DUTY, 30);
    send_word(OP_SET_RGB, 32'h3, 32'h3, 32'h1, 32'h0, 1'b1);
    send_tick();
    send_tick();
    // restart the open while one is still running
    send_word(OP_SET_RGB, 32'h3, 32'h3, 32'h1, 32'h0, 1'b1);
    send_tick();
    send_tick();
    send_tick();
    set_reg(CFG_HEAT_LIMIT, board_heat - 1);
    send_word(OP_SET_RGB, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    set_reg(CFG_HEAT_LIMIT, board_heat);
    send_word(OP_SET_RGB, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
  endtask

  // Sink holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    drain_results();
    tx_idle_on = 1'b0;
    hold_off_cycles = 80;
    for (int i = 0; i < 16; i++)
      send_word(i[0] ? OP_TICK : OP_SET_RGB, $urandom, $urandom, $urandom, $urandom,
                1'($urandom_range(1)));
    tx_idle_on = 1'b1;
  endtask

  // Random words over several register settings, extremes first
  task automatic test_random_traffic();
    int pick;
    int lim;
    logic [1:0] op;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        set_reg(CFG_BRIGHTNESS, 0);
        set_reg(CFG_DUTY, 0);
        set_reg(CFG_OPEN_TICKS, 0);
        set_reg(CFG_HEAT_LIMIT, 0);
      end else if (phase == 1) begin
        set_reg(CFG_BRIGHTNESS, 511);
        set_reg(CFG_DUTY, 127);
        set_reg(CFG_OPEN_TICKS, 65535);
        set_reg(CFG_HEAT_LIMIT, HEAT_TOP);
      end else begin
        set_reg(CFG_BRIGHTNESS, $urandom_range(2) == 0 ? 256 : $urandom_range(511));
        set_reg(CFG_DUTY, $urandom_range(3) == 0 ? 100 : $urandom_range(127));
        set_reg(CFG_OPEN_TICKS,
                $urandom_range(4) == 0 ? $urandom_range(65535) : $urandom_range(20));
        // keep the limit near the current heat so grants and refusals both occur
        pick = $urandom_range(3);
        if (pick == 0) lim = $urandom & HEAT_TOP;
        else lim = board_heat + $urandom_range(300) - 150;
        if (lim < 0) lim = 0;
        if (lim > HEAT_TOP) lim = HEAT_TOP;
        set_reg(CFG_HEAT_LIMIT, lim);
      end
      // phase 3 runs flat out on both sides
      tx_idle_on = (phase != 3);
      rx_idle_on = (phase != 3);
      for (int n = 0; n < 45; n++) begin
        pick = $urandom_range(99);
        if (pick < 45) op = OP_TICK;
        else if (pick < 70) op = OP_SET_RGB;
        else if (pick < 88) op = OP_SET_BLUE;
        else op = OP_UNUSED;
        send_word(op, $urandom, $urandom, $urandom, $urandom, $urandom_range(99) < 60);
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Ramp heat at the full rise rate, then probe the limit around the current heat
  task automatic test_heat_ramp();
    set_reg(CFG_DUTY, 0);
    set_reg(CFG_OPEN_TICKS, 65535);
    set_reg(CFG_HEAT_LIMIT, HEAT_TOP);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_word(OP_SET_RGB, $urandom, $urandom, $urandom, $urandom, 1'b1);
    repeat (12) send_tick();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_word(OP_SET_RGB, $urandom, $urandom, $urandom, $urandom, 1'b1);
    set_reg(CFG_HEAT_LIMIT, board_heat - 1);
    send_word(OP_SET_RGB, $urandom, $urandom, $urandom, $urandom, 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_operation = OP_TICK;
    in_red_pattern = '0;
    in_green_pattern = '0;
    in_buzzer_pattern = '0;
    in_blue_pattern = '0;
    in_open_request = 1'b0;
    reset_board_image();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on();
    test_pattern_shift();
    test_brightness_extremes();
    test_relay_heat();
    test_backpressure();
    test_random_traffic();
    test_heat_ramp();

    drain_results();
    repeat (5) @(posedge clk);
    $display("Covered %0d result words, %0d register writes, %0d grants, %0d refusals.",
             results_checked, cfg_writes, grants, refusals);
    $display("Heat peaked at %0d; %0d mismatches seen.", peak_heat, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run
  initial begin
    #8_000_000;
    $display("Timed out with %0d results still owed.", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- blink_pattern_relay_duty_limiter.f -----
+incdir+rtl
rtl/bprdl_pkg.sv
rtl/bprdl_front.sv
rtl/bprdl_queue.sv
rtl/bprdl_back.sv
rtl/blink_pattern_relay_duty_limiter.sv
verif/blink_pattern_relay_duty_limiter_tb.sv
